// File: rtl/assert_macros.svh
// Assertion macros used by partition_fit_allocator_top of the partition fit allocator.
// Depends on nothing; each macro expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pfa_pkg.sv
// Shared types and constants of the partition fit allocator.
// No dependencies; used by pfa_cell and partition_fit_allocator_top.
package pfa_pkg;

    localparam int NUM_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_COUNT = 2'd1;

    localparam logic [4:0] PARTITION_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2,
        POLICY_NEXT  = 2'd3
    } policy_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_ALLOC = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STATUS_ALLOCATED = 2'd0,
        STATUS_NO_FIT    = 2'd1,
        STATUS_SKIPPED   = 2'd2,
        STATUS_LOADED    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        command_t    command;
        logic [3:0]  partition_select;
        logic [15:0] partition_size;
        logic [15:0] request_size;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  chosen_partition;
        logic [15:0] remaining_size;
    } result_t;

endpackage

// File: rtl/pfa_cell.sv
// One partition cell: holds a free size and updates the passing scan record.
// Depends on pfa_pkg.
module pfa_cell #(
    parameter int CELL_INDEX = 0,
    parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int WI_W       = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfa_pkg::policy_t     policy,
    input  logic [CNT_W-1:0]     active_count,
    input  logic [CNT_W-1:0]     start_index,
    input  logic [SIZE_BITS-1:0] request,
    input  logic                 wr_en,
    input  logic [WI_W-1:0]      wr_index,
    input  logic [SIZE_BITS-1:0] wr_value,
    input  logic                 in_found,
    input  logic [IDX_W-1:0]     in_index,
    input  logic [SIZE_BITS-1:0] in_value,
    input  logic                 in_wrap_found,
    input  logic [IDX_W-1:0]     in_wrap_index,
    input  logic [SIZE_BITS-1:0] in_wrap_value,
    output logic                 out_found,
    output logic [IDX_W-1:0]     out_index,
    output logic [SIZE_BITS-1:0] out_value,
    output logic                 out_wrap_found,
    output logic [IDX_W-1:0]     out_wrap_index,
    output logic [SIZE_BITS-1:0] out_wrap_value
);

    logic [SIZE_BITS-1:0] entry_reg;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic [SIZE_BITS-1:0] value_reg, value_next;
    logic                 wrap_found_reg, wrap_found_next;
    logic [IDX_W-1:0]     wrap_index_reg, wrap_index_next;
    logic [SIZE_BITS-1:0] wrap_value_reg, wrap_value_next;
    logic                 fits;
    logic                 upper;
    logic                 take;
    logic                 take_wrap;

    assign fits  = (CNT_W'(CELL_INDEX) < active_count) && (entry_reg >= request);
    assign upper = CNT_W'(CELL_INDEX) >= start_index;

    always_comb
    begin
        take      = 1'b0;
        take_wrap = 1'b0;
        unique case (policy)
            pfa_pkg::POLICY_FIRST: take = fits && !in_found;
            pfa_pkg::POLICY_BEST:  take = fits && (!in_found || entry_reg < in_value);
            pfa_pkg::POLICY_WORST: take = fits && (!in_found || entry_reg > in_value);
            pfa_pkg::POLICY_NEXT:
            begin
                take      = fits && upper && !in_found;
                take_wrap = fits && !upper && !in_wrap_found;
            end
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        found_next      = in_found || take;
        index_next      = take ? IDX_W'(CELL_INDEX) : in_index;
        value_next      = take ? entry_reg : in_value;
        wrap_found_next = in_wrap_found || take_wrap;
        wrap_index_next = take_wrap ? IDX_W'(CELL_INDEX) : in_wrap_index;
        wrap_value_next = take_wrap ? entry_reg : in_wrap_value;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_index == WI_W'(CELL_INDEX))
        begin
            entry_reg <= wr_value;
        end
        index_reg      <= index_next;
        value_reg      <= value_next;
        wrap_index_reg <= wrap_index_next;
        wrap_value_reg <= wrap_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            wrap_found_reg <= 1'b0;
        end
        else
        begin
            found_reg      <= found_next;
            wrap_found_reg <= wrap_found_next;
        end
    end

    assign out_found      = found_reg;
    assign out_index      = index_reg;
    assign out_value      = value_reg;
    assign out_wrap_found = wrap_found_reg;
    assign out_wrap_index = wrap_index_reg;
    assign out_wrap_value = wrap_value_reg;

endmodule

// File: rtl/partition_fit_allocator_top.sv
// Top level of the partition fit allocator: control, config registers, cell chain.
// Depends on pfa_pkg, pfa_cell and assert_macros.svh.
//
// Usage:
//   Command channel: an item (load or allocate) transfers on a rising edge with
//   start high and busy low. Each item yields one result on the result port,
//   valid for exactly one cycle while done is high; the receiver cannot stall.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Index 0 sets the policy, index 1 the partition count. Write
//   config only while idle.
//   Results: a load or a skipped request gives its result in the cycle after the
//   transfer. An allocate enters ST_SCAN while the scan record walks the cell
//   chain one cell per cycle, then ST_FINISH picks the winner, writes the reduced
//   size back into its cell and registers the result.
//   One item is in flight at a time; busy is high in an allocate's scan and finish,
//   and a new item can transfer in the cycle its predecessor's result shows.
//   Reset: control, policy (first fit), count (16), stop flag and next-fit
//   pointer are cleared; partition sizes are undefined until loaded.
`include "assert_macros.svh"

module partition_fit_allocator_top #(
    parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pfa_pkg::item_t                   item,
    output logic                             done,
    output pfa_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = ($clog2(NUM_PARTITIONS + 1) > 5) ? $clog2(NUM_PARTITIONS + 1) : 5;
    localparam int WI_W  = IDX_W + 4;

    pfa_pkg::state_t      state_reg, state_next;
    pfa_pkg::policy_t     policy_reg, policy_next;
    logic [4:0]           count_reg, count_next;
    logic                 stopped_reg, stopped_next;
    logic [3:0]           rover_reg, rover_next;
    logic [IDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic                 done_reg, done_next;
    pfa_pkg::result_t     result_reg, result_next;

    logic                 accept;
    logic [CNT_W-1:0]     count_ext;
    logic [CNT_W-1:0]     active_count;
    logic [CNT_W-1:0]     rover_ext;
    logic [CNT_W-1:0]     start_index;
    logic [SIZE_BITS+15:0] req_wide;
    logic [SIZE_BITS+15:0] psize_wide;
    logic                 wr_en;
    logic [WI_W-1:0]      wr_index;
    logic [SIZE_BITS-1:0] wr_value;
    logic                 pick_found;
    logic [IDX_W-1:0]     pick_index;
    logic [SIZE_BITS-1:0] pick_value;
    logic [SIZE_BITS-1:0] remain;
    logic [SIZE_BITS+15:0] remain_wide;
    logic [IDX_W+3:0]     pick_wide;

    logic                 chain_found [NUM_PARTITIONS+1];
    logic [IDX_W-1:0]     chain_index [NUM_PARTITIONS+1];
    logic [SIZE_BITS-1:0] chain_value [NUM_PARTITIONS+1];
    logic                 chain_wrap_found [NUM_PARTITIONS+1];
    logic [IDX_W-1:0]     chain_wrap_index [NUM_PARTITIONS+1];
    logic [SIZE_BITS-1:0] chain_wrap_value [NUM_PARTITIONS+1];

    assign busy      = state_reg != pfa_pkg::ST_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign count_ext    = CNT_W'(count_reg);
    assign active_count = (count_reg == 5'd0) ? CNT_W'(1) :
                          (count_ext > CNT_W'(NUM_PARTITIONS)) ? CNT_W'(NUM_PARTITIONS) :
                          count_ext;
    assign rover_ext    = CNT_W'(rover_reg);
    assign start_index  = (rover_ext < active_count) ? rover_ext : '0;

    assign req_wide   = {{SIZE_BITS{1'b0}}, item.request_size};
    assign psize_wide = {{SIZE_BITS{1'b0}}, item.partition_size};

    // cell chain
    assign chain_found[0]      = 1'b0;
    assign chain_index[0]      = '0;
    assign chain_value[0]      = '0;
    assign chain_wrap_found[0] = 1'b0;
    assign chain_wrap_index[0] = '0;
    assign chain_wrap_value[0] = '0;

    for (genvar g = 0; g < NUM_PARTITIONS; g++)
    begin : g_cell
        pfa_cell #(
            .CELL_INDEX (g),
            .SIZE_BITS  (SIZE_BITS),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .WI_W       (WI_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .policy         (policy_reg),
            .active_count   (active_count),
            .start_index    (start_index),
            .request        (req_reg),
            .wr_en          (wr_en),
            .wr_index       (wr_index),
            .wr_value       (wr_value),
            .in_found       (chain_found[g]),
            .in_index       (chain_index[g]),
            .in_value       (chain_value[g]),
            .in_wrap_found  (chain_wrap_found[g]),
            .in_wrap_index  (chain_wrap_index[g]),
            .in_wrap_value  (chain_wrap_value[g]),
            .out_found      (chain_found[g+1]),
            .out_index      (chain_index[g+1]),
            .out_value      (chain_value[g+1]),
            .out_wrap_found (chain_wrap_found[g+1]),
            .out_wrap_index (chain_wrap_index[g+1]),
            .out_wrap_value (chain_wrap_value[g+1])
        );
    end

    // wrap candidate only exists under next fit
    assign pick_found  = chain_found[NUM_PARTITIONS] || chain_wrap_found[NUM_PARTITIONS];
    assign pick_index  = chain_found[NUM_PARTITIONS] ? chain_index[NUM_PARTITIONS] :
                         chain_wrap_index[NUM_PARTITIONS];
    assign pick_value  = chain_found[NUM_PARTITIONS] ? chain_value[NUM_PARTITIONS] :
                         chain_wrap_value[NUM_PARTITIONS];
    assign remain      = pick_value - req_reg;
    assign remain_wide = {16'b0, remain};
    assign pick_wide   = {4'b0, pick_index};

    // config registers
    always_comb
    begin
        policy_next = policy_reg;
        count_next  = count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pfa_pkg::REG_POLICY_MODE:     policy_next = pfa_pkg::policy_t'(cfg_data[1:0]);
                pfa_pkg::REG_PARTITION_COUNT: count_next  = cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                if (accept && item.command == pfa_pkg::CMD_ALLOC && !stopped_reg)
                begin
                    state_next = pfa_pkg::ST_SCAN;
                end
            end
            pfa_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == IDX_W'(NUM_PARTITIONS - 1))
                begin
                    state_next = pfa_pkg::ST_FINISH;
                end
            end
            pfa_pkg::ST_FINISH: state_next = pfa_pkg::ST_IDLE;
            default:            state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        stopped_next  = stopped_reg;
        rover_next    = rover_reg;
        scan_cnt_next = '0;
        req_next      = req_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_index      = WI_W'(item.partition_select);
        wr_value      = psize_wide[SIZE_BITS-1:0];
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                req_next = req_wide[SIZE_BITS-1:0];
                if (accept)
                begin
                    result_next.chosen_partition = '0;
                    result_next.remaining_size   = '0;
                    if (item.command == pfa_pkg::CMD_LOAD)
                    begin
                        wr_en              = 1'b1;
                        stopped_next       = 1'b0;
                        rover_next         = '0;
                        done_next          = 1'b1;
                        result_next.status = pfa_pkg::STATUS_LOADED;
                    end
                    else if (stopped_reg)
                    begin
                        done_next          = 1'b1;
                        result_next.status = pfa_pkg::STATUS_SKIPPED;
                    end
                end
            end
            pfa_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            pfa_pkg::ST_FINISH:
            begin
                done_next = 1'b1;
                if (pick_found)
                begin
                    wr_en                        = 1'b1;
                    wr_index                     = WI_W'(pick_index);
                    wr_value                     = remain;
                    rover_next                   = pick_wide[3:0];
                    result_next.status           = pfa_pkg::STATUS_ALLOCATED;
                    result_next.chosen_partition = pick_wide[3:0];
                    result_next.remaining_size   = remain_wide[15:0];
                end
                else
                begin
                    stopped_next                 = 1'b1;
                    result_next.status           = pfa_pkg::STATUS_NO_FIT;
                    result_next.chosen_partition = '0;
                    result_next.remaining_size   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pfa_pkg::ST_IDLE;
            policy_reg   <= pfa_pkg::POLICY_FIRST;
            count_reg    <= pfa_pkg::PARTITION_COUNT_RESET;
            stopped_reg  <= 1'b0;
            rover_reg    <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            policy_reg   <= policy_next;
            count_reg    <= count_next;
            stopped_reg  <= stopped_next;
            rover_reg    <= rover_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    `ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while busy")
    `ASSERT_NEXT(a_load_result, accept && item.command == pfa_pkg::CMD_LOAD,
                 done && result.status == pfa_pkg::STATUS_LOADED, "load result missing")
    `ASSERT_NEXT(a_skip_result, accept && item.command == pfa_pkg::CMD_ALLOC && stopped_reg,
                 done && result.status == pfa_pkg::STATUS_SKIPPED, "skip result missing")
    `ASSERT_IMPL(a_zero_fields, done && result.status != pfa_pkg::STATUS_ALLOCATED,
                 result.chosen_partition == 4'd0 && result.remaining_size == 16'd0,
                 "nonzero fields without allocation")

endmodule
